// ===== rtl/core/pba_pkg.sv =====
// ============================================================================
// pba_pkg - shared constants and types of the PUF bit-aliasing accumulator
// Sizes, command and status codes, channel items and inter-module structs.
// ============================================================================
package pba_pkg;

   // Sizing
   localparam int MAX_BYTES     = 64;
   localparam int COUNT_WIDTH   = 16;
   localparam int FRAC_BITS     = 16;
   localparam int BITS_PER_BYTE = 8;
   localparam int NUM_BITS      = MAX_BYTES * BITS_PER_BYTE;

   // Field widths of the channel items
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int BIDX_W   = 9;
   localparam int STAT_W   = 3;
   localparam int FRAC_W   = 17;
   localparam int CNT_W    = 16;
   localparam int ROW_W    = 16;

   // Derived internal widths
   localparam int POS_W    = $clog2(MAX_BYTES + 1);
   localparam int ADDR_W   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int SEL_W    = $clog2(BITS_PER_BYTE);
   localparam int WORD_W   = BITS_PER_BYTE * COUNT_WIDTH;
   localparam int QUOT_W   = FRAC_BITS + 1;
   localparam int STEP_W   = $clog2(FRAC_BITS + 1);

   // Row limit: lesser of 2^16-1 and 2^COUNT_WIDTH-1
   localparam logic [ROW_W-1:0] ROW_LIMIT = (COUNT_WIDTH >= 16) ? ROW_W'(16'hFFFF)
                                           : ROW_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   // Commands
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ERROR   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NO_ROWS = 3'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_PARTIAL = 3'd4;

   // Memory operations carried down the pipe
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_FIRST = 2'd1;
   localparam logic [1:0] OP_ADD   = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
      logic              row_end;
      logic [BIDX_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [FRAC_W-1:0] fraction;
      logic [CNT_W-1:0]  bit_count;
      logic [ROW_W-1:0]  row_count;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/pba_counter_ram.sv =====
// ============================================================================
// pba_counter_ram - counter store
// One word per response byte, eight bit counters per word; registered read.
// ============================================================================
module pba_counter_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [pba_pkg::ADDR_W-1:0]    rd_addr,
   output logic [pba_pkg::WORD_W-1:0]    rd_data,
   input  pba_pkg::ram_wr_type           wr
);

   logic [pba_pkg::WORD_W-1:0] mem [pba_pkg::MAX_BYTES];
   logic [pba_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pba_divider.sv =====
// ============================================================================
// pba_divider - fraction divider
// Restoring division, one quotient bit per cycle: floor(count*2^F/rows).
// ============================================================================
module pba_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          ack,
   input  logic [pba_pkg::ROW_W-1:0]     dividend,
   input  logic [pba_pkg::ROW_W-1:0]     divisor,
   output pba_pkg::div_stat_type         stat,
   output logic [pba_pkg::QUOT_W-1:0]    quotient
);

   localparam int RW = pba_pkg::ROW_W;
   localparam int QW = pba_pkg::QUOT_W;
   localparam int SW = pba_pkg::STEP_W;

   logic [RW-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [RW:0]   shifted, diff;
   logic          ge, top;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, dvsr_ff};
      ge      = shifted >= {1'b0, dvsr_ff};
      top     = dividend >= divisor;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         // count <= rows, so the integer bit is a single compare
         rem_in  = top ? (dividend - divisor) : dividend;
         dvsr_in = divisor;
         quot_in = QW'(top);
         step_in = SW'(pba_pkg::FRAC_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? RW'(diff) : RW'(shifted);
         quot_in = {quot_ff[QW-2:0], ge};
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

// ===== rtl/core/puf_bit_aliasing_accumulator_core.sv =====
// ============================================================================
// puf_bit_aliasing_accumulator_core - PUF bit-aliasing accumulator
// Per-bit ones counters over response rows, with ones-fraction readout.
// ============================================================================
//
//  channel  ports                          item      direction
//  -------  -----------------------------  --------  ---------
//  request  req_valid req_stall req_item   req_type  in
//  response rsp_valid rsp_stall rsp_item   rsp_type  out
//
//  Pushes, clears and failed reads: one item per cycle while the response
//  is not stalled, through stage B and the output register. An ok read
//  holds stage B while the bit-serial divider runs; later items wait behind it.
//  Reset is synchronous; the counter RAM is not cleared, the first row
//  writes its counters outright. A stalled response holds the pipe.
//
module puf_bit_aliasing_accumulator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pba_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pba_pkg::rsp_type rsp_item
);

   localparam int PW = pba_pkg::POS_W;
   localparam int AW = pba_pkg::ADDR_W;
   localparam int CW = pba_pkg::COUNT_WIDTH;
   localparam int NB = pba_pkg::BITS_PER_BYTE;

   // ---------------------------------------------------------------------
   // Aggregate control state
   // ---------------------------------------------------------------------
   logic [PW-1:0]             learned_ff, learned_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [pba_pkg::ROW_W-1:0] rows_ff, rows_in;
   logic                      known_ff, known_in;
   logic                      sticky_ff, sticky_in;

   // Stage A decode results
   logic                         accept;
   logic [1:0]                   a_op;
   logic [AW-1:0]                a_addr;
   logic [pba_pkg::STAT_W-1:0]   a_status;
   logic                         a_hazard;

   // Stage B: memory data available
   logic                         b_valid_ff, b_valid_in;
   logic [1:0]                   b_op_ff;
   logic [AW-1:0]                b_addr_ff;
   logic [pba_pkg::BYTE_W-1:0]   b_byte_ff;
   logic [pba_pkg::SEL_W-1:0]    b_sel_ff;
   logic [pba_pkg::STAT_W-1:0]   b_status_ff;
   logic [pba_pkg::ROW_W-1:0]    b_rows_ff;
   logic                         b_fwd_ff;
   logic [pba_pkg::WORD_W-1:0]   fwd_word_ff;

   logic [pba_pkg::WORD_W-1:0]   ram_rd_data, b_word, wr_word;
   logic [CW-1:0]                b_count;
   logic                         b_is_write, b_read_ok, b_done, out_free;
   pba_pkg::ram_wr_type          ram_wr;

   // Divider
   logic                         div_start;
   pba_pkg::div_stat_type        div_stat;
   logic [pba_pkg::QUOT_W-1:0]   div_quot;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_type             rsp_item_ff, rsp_item_in;

   // ---------------------------------------------------------------------
   // Handshake: stage B drains into the output register when that is free
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign b_is_write = (b_op_ff == pba_pkg::OP_FIRST) || (b_op_ff == pba_pkg::OP_ADD);
   assign b_read_ok  = (b_op_ff == pba_pkg::OP_READ);
   assign b_done     = b_valid_ff && out_free && (!b_read_ok || div_stat.done);
   assign req_stall  = b_valid_ff && !b_done;
   assign accept     = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Stage A: command decode and control-state update. Everything except
   // the counter values is settled here, so the next item sees it at once.
   // ---------------------------------------------------------------------
   always_comb begin
      learned_in = learned_ff;
      pos_in     = pos_ff;
      rows_in    = rows_ff;
      known_in   = known_ff;
      sticky_in  = sticky_ff;
      a_op       = pba_pkg::OP_NONE;
      a_addr     = AW'(pos_ff);
      a_status   = pba_pkg::STAT_OK;
      if (accept) begin
         unique case (req_item.command)
            pba_pkg::CMD_PUSH: begin
               if (!sticky_ff) begin
                  if (!known_ff) begin
                     // first row: learn length, overwrite counters
                     if (32'(pos_ff) >= pba_pkg::MAX_BYTES) begin
                        sticky_in = 1'b1;
                     end else begin
                        a_op   = pba_pkg::OP_FIRST;
                        pos_in = pos_ff + PW'(1);
                        if (req_item.row_end) begin
                           learned_in = pos_ff + PW'(1);
                           known_in   = 1'b1;
                           pos_in     = '0;
                           rows_in    = pba_pkg::ROW_W'(1);
                        end
                     end
                  end else if (rows_ff >= pba_pkg::ROW_LIMIT || pos_ff >= learned_ff ||
                               32'(pos_ff) >= pba_pkg::MAX_BYTES) begin
                     sticky_in = 1'b1;
                  end else if (req_item.row_end && (pos_ff + PW'(1) != learned_ff)) begin
                     sticky_in = 1'b1;   // row ends short
                  end else begin
                     a_op   = pba_pkg::OP_ADD;
                     pos_in = pos_ff + PW'(1);
                     if (req_item.row_end) begin
                        pos_in  = '0;
                        rows_in = rows_ff + pba_pkg::ROW_W'(1);
                     end
                  end
               end
               a_status = sticky_in ? pba_pkg::STAT_ERROR : pba_pkg::STAT_OK;
            end
            pba_pkg::CMD_READ: begin
               a_addr = AW'(req_item.bit_index[pba_pkg::BIDX_W-1:pba_pkg::SEL_W]);
               if (sticky_ff) begin
                  a_status = pba_pkg::STAT_ERROR;
               end else if (rows_ff == '0) begin
                  a_status = pba_pkg::STAT_NO_ROWS;
               end else if (pos_ff != '0) begin
                  a_status = pba_pkg::STAT_PARTIAL;
               end else if (32'(req_item.bit_index) >= 32'(learned_ff) * NB ||
                            32'(req_item.bit_index) >= pba_pkg::NUM_BITS) begin
                  a_status = pba_pkg::STAT_RANGE;
               end else begin
                  a_op = pba_pkg::OP_READ;
               end
            end
            pba_pkg::CMD_CLEAR: begin
               learned_in = '0;
               pos_in     = '0;
               rows_in    = '0;
               known_in   = 1'b0;
               sticky_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Write in stage B during this cycle to the word being read: the RAM
   // returns the old word, so stage B takes the forwarded copy instead.
   assign a_hazard = b_done && b_is_write && (b_addr_ff == a_addr);

   // ---------------------------------------------------------------------
   // Stage B: modify counters, write back, or hand the count to the divider
   // ---------------------------------------------------------------------
   assign b_word  = b_fwd_ff ? fwd_word_ff : ram_rd_data;
   assign b_count = b_word[b_sel_ff*CW +: CW];

   always_comb begin
      for (int b = 0; b < NB; b++) begin
         if (b_op_ff == pba_pkg::OP_FIRST) begin
            wr_word[b*CW +: CW] = CW'(b_byte_ff[b]);
         end else begin
            wr_word[b*CW +: CW] = b_word[b*CW +: CW] + CW'(b_byte_ff[b]);
         end
      end
   end

   assign ram_wr.en   = b_done && b_is_write;
   assign ram_wr.addr = b_addr_ff;
   assign ram_wr.data = wr_word;

   assign div_start = b_valid_ff && b_read_ok && !div_stat.busy && !div_stat.done;

   pba_counter_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (a_addr),
      .rd_data (ram_rd_data),
      .wr      (ram_wr)
   );

   pba_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ack      (b_done),
      .dividend (pba_pkg::ROW_W'(b_count)),
      .divisor  (b_rows_ff),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------------
   // Result assembly and output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_item_in.status    = b_status_ff;
      rsp_item_in.fraction  = '0;
      rsp_item_in.bit_count = '0;
      rsp_item_in.row_count = b_rows_ff;
      if (b_read_ok) begin
         rsp_item_in.fraction  = pba_pkg::FRAC_W'(div_quot);
         rsp_item_in.bit_count = pba_pkg::CNT_W'(b_count);
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_op_ff     <= a_op;
         b_addr_ff   <= a_addr;
         b_byte_ff   <= req_item.data_byte;
         b_sel_ff    <= req_item.bit_index[pba_pkg::SEL_W-1:0];
         b_status_ff <= a_status;
         b_rows_ff   <= rows_in;
         b_fwd_ff    <= a_hazard;
      end
      if (ram_wr.en) begin
         fwd_word_ff <= wr_word;
      end
      if (b_done) begin
         rsp_item_ff <= rsp_item_in;
      end
      if (reset) begin
         learned_ff   <= '0;
         pos_ff       <= '0;
         rows_ff      <= '0;
         known_ff     <= 1'b0;
         sticky_ff    <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         learned_ff   <= learned_in;
         pos_ff       <= pos_in;
         rows_ff      <= rows_in;
         known_ff     <= known_in;
         sticky_ff    <= sticky_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (b_valid_ff && b_op_ff == pba_pkg::OP_READ))
      else $error("divider running without a read in stage B");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != pba_pkg::STAT_OK) |->
         (rsp_item.fraction == '0 && rsp_item.bit_count == '0))
      else $error("failed item carries a fraction or count");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      known_ff |-> (learned_ff != '0 && 32'(learned_ff) <= pba_pkg::MAX_BYTES))
      else $error("learned row length out of range");

   a_read_order: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_read_ok && !div_stat.done) |=> $stable(b_rows_ff))
      else $error("stage B read changed while waiting on divider");

endmodule
